@@ sv/pvdsw_pkg.sv @@
// shared types, constants and helpers for the digipot serial write block
// used by every module of the block; depends on nothing
package pvdsw_pkg;

    // channel count and value limits
    localparam int unsigned CHANNELS = 4;
    localparam logic [15:0] VALUE_MIN = 16'd1000;
    localparam logic [15:0] VALUE_MAX = 16'd2000;
    localparam logic [23:0] OHMS_MAX = 24'd10000;
    localparam logic [7:0] CMD_BYTE = 8'h13;
    localparam int unsigned FRAME_BITS = 16;

    // configuration register indexes and reset values
    localparam int unsigned CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIPER = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL = 4'd3;
    localparam logic [63:0] BASE_RESET = 64'h03E8_03E8_03E8_03E8;
    localparam logic [63:0] PROP_RESET = 64'h0100_0100_0100_0100;
    localparam logic [63:0] WIPER_RESET = 64'h0000_0000_0000_0000;
    localparam logic [63:0] FULL_RESET = 64'h2710_2710_2710_2710;

    // shared divider: 24-bit dividend, four quotient bits per cycle
    localparam int unsigned DVD_W = 24;
    localparam int unsigned DIV_BITS = 4;
    localparam int unsigned DIV_PASSES = DVD_W / DIV_BITS;

    // queue between front and back
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW = $clog2(Q_DEPTH);

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_CHAN  = 2'd2,
        ST_OHMS  = 2'd3
    } status_t;

    // one classified request as handed from front to back
    typedef struct packed {
        status_t     status;
        logic [2:0]  target;
        logic [7:0]  code;
    } entry_t;

    // pick one 16-bit lane out of a four-lane register
    function automatic logic [15:0] lane_sel(input logic [63:0] lanes,
                                             input logic [1:0] idx);
        lane_sel = lanes[{idx, 4'b0000} +: 16];
    endfunction

endpackage

@@ sv/pvdsw_queue.sv @@
// small fifo of classified requests between front and back
// depends on pvdsw_pkg for the entry type and depth
module pvdsw_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  pvdsw_pkg::entry_t  push_entry,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output pvdsw_pkg::entry_t  head
);

    pvdsw_pkg::entry_t slot_reg [pvdsw_pkg::Q_DEPTH];
    logic [pvdsw_pkg::Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [pvdsw_pkg::Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [pvdsw_pkg::Q_AW:0]   count_reg, count_next;
    logic                       do_push, do_pop;

    assign full    = (count_reg == (pvdsw_pkg::Q_AW+1)'(pvdsw_pkg::Q_DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + (do_push ? 1'b1 : 1'b0);
        rd_ptr_next = rd_ptr_reg + (do_pop ? 1'b1 : 1'b0);
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ sv/pvdsw_front.sv @@
// front end: accepts requests, checks them and works out the wiper code
// with a shared radix-16 restoring divider; depends on pvdsw_pkg
module pvdsw_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [23:0]        s_tdata,     // [2:0] channel, [18:3] control_value
    input  logic [63:0]        base_values,
    input  logic [63:0]        proportions,
    input  logic [63:0]        wiper_ohms,
    input  logic [63:0]        full_scale_ohms,
    input  logic               q_full,
    output logic               q_push,
    output pvdsw_pkg::entry_t  q_entry
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_DIV1 = 4'b0010,
        F_MID  = 4'b0100,
        F_DIV2 = 4'b1000
    } fstate_t;

    // push is a flag beside the state so a result and a new request share a cycle
    fstate_t                  state_reg, state_next;
    logic                     pend_reg, pend_next;
    logic [1:0]               lane_reg, lane_next;
    logic [2:0]               target_reg, target_next;
    pvdsw_pkg::status_t       status_reg, status_next;
    logic [7:0]               code_reg, code_next;
    logic                     neg_reg, neg_next;
    logic [pvdsw_pkg::DVD_W-1:0] dvd_reg, dvd_next;
    logic [15:0]              rem_reg, rem_next;
    logic [15:0]              div_reg, div_next;
    logic [2:0]               cnt_reg, cnt_next;

    logic                     accept;
    logic [2:0]               in_ch;
    logic [15:0]              in_val;
    logic [1:0]               in_lane;
    logic                     val_ok, ch_ok, zero_div;
    logic [15:0]              a_base, a_prop, a_full;
    logic [17:0]              diff1, diff2;
    logic [15:0]              mag1, mag2;
    logic                     r_bad;
    logic [13:0]              r_ohms;
    logic [pvdsw_pkg::DVD_W-1:0] step_dvd;
    logic [16:0]              step_rem;
    logic                     pass_last;

    // request fields and checks
    assign in_ch    = s_tdata[2:0];
    assign in_val   = s_tdata[18:3];
    assign in_lane  = in_ch[1:0] - 2'd1;
    assign val_ok   = (in_val >= pvdsw_pkg::VALUE_MIN) && (in_val <= pvdsw_pkg::VALUE_MAX);
    assign ch_ok    = (in_ch != 3'd0) && (in_ch <= 3'(pvdsw_pkg::CHANNELS));
    assign a_base   = pvdsw_pkg::lane_sel(base_values, in_lane);
    assign a_prop   = pvdsw_pkg::lane_sel(proportions, in_lane);
    assign a_full   = pvdsw_pkg::lane_sel(full_scale_ohms, in_lane);
    assign zero_div = (a_prop == 16'd0) || (a_full == 16'd0);
    assign diff1    = {2'b00, in_val} - {2'b00, a_base};
    assign mag1     = diff1[17] ? 16'(18'd0 - diff1) : diff1[15:0];

    // resistance check and second numerator
    assign r_bad  = neg_reg ? (dvd_reg != '0) : (dvd_reg > pvdsw_pkg::OHMS_MAX);
    assign r_ohms = neg_reg ? 14'd0 : dvd_reg[13:0];
    assign diff2  = {4'b0000, r_ohms}
                  - {2'b00, pvdsw_pkg::lane_sel(wiper_ohms, lane_reg)};
    assign mag2   = diff2[17] ? 16'(18'd0 - diff2) : diff2[15:0];

    // four restoring division steps per cycle
    always_comb begin
        step_dvd = dvd_reg;
        step_rem = {1'b0, rem_reg};
        for (int i = 0; i < pvdsw_pkg::DIV_BITS; i++) begin
            step_rem = {step_rem[15:0], step_dvd[pvdsw_pkg::DVD_W-1]};
            step_dvd = {step_dvd[pvdsw_pkg::DVD_W-2:0], 1'b0};
            if (step_rem >= {1'b0, div_reg}) begin
                step_rem    = step_rem - {1'b0, div_reg};
                step_dvd[0] = 1'b1;
            end
        end
    end

    assign pass_last = (cnt_reg == 3'(pvdsw_pkg::DIV_PASSES - 1));

    // handshakes
    assign s_tready = (state_reg == F_IDLE) && (!pend_reg || !q_full);
    assign accept   = s_tvalid && s_tready;
    assign q_push   = pend_reg;
    assign q_entry  = '{status: status_reg, target: target_reg, code: code_reg};

    // sequencing
    always_comb begin
        state_next  = state_reg;
        pend_next   = pend_reg && q_full;
        lane_next   = lane_reg;
        target_next = target_reg;
        status_next = status_reg;
        code_next   = code_reg;
        neg_next    = neg_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        cnt_next    = cnt_reg;
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    target_next = 3'd0;
                    code_next   = 8'd0;
                    if (!val_ok) begin
                        status_next = pvdsw_pkg::ST_RANGE;
                        pend_next   = 1'b1;
                    end else if (!ch_ok) begin
                        status_next = pvdsw_pkg::ST_CHAN;
                        pend_next   = 1'b1;
                    end else if (zero_div) begin
                        status_next = pvdsw_pkg::ST_OHMS;
                        pend_next   = 1'b1;
                    end else begin
                        lane_next   = in_lane;
                        target_next = in_ch;
                        neg_next    = diff1[17];
                        dvd_next    = {mag1, 8'h00};
                        rem_next    = 16'd0;
                        div_next    = a_prop;
                        cnt_next    = 3'd0;
                        state_next  = F_DIV1;
                    end
                end
            end
            F_DIV1: begin
                dvd_next = step_dvd;
                rem_next = step_rem[15:0];
                cnt_next = cnt_reg + 3'd1;
                if (pass_last) begin
                    state_next = F_MID;
                end
            end
            F_MID: begin
                if (r_bad) begin
                    status_next = pvdsw_pkg::ST_OHMS;
                    target_next = 3'd0;
                    pend_next   = 1'b1;
                    state_next  = F_IDLE;
                end else begin
                    neg_next   = diff2[17];
                    dvd_next   = {mag2, 8'h00};
                    rem_next   = 16'd0;
                    div_next   = pvdsw_pkg::lane_sel(full_scale_ohms, lane_reg);
                    cnt_next   = 3'd0;
                    state_next = F_DIV2;
                end
            end
            F_DIV2: begin
                dvd_next = step_dvd;
                rem_next = step_rem[15:0];
                cnt_next = cnt_reg + 3'd1;
                if (pass_last) begin
                    // code is the negated quotient modulo 256
                    code_next   = neg_reg ? step_dvd[7:0] : 8'd0 - step_dvd[7:0];
                    status_next = pvdsw_pkg::ST_OK;
                    pend_next   = 1'b1;
                    state_next  = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
                pend_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        lane_reg   <= lane_next;
        target_reg <= target_next;
        status_reg <= status_next;
        code_reg   <= code_next;
        neg_reg    <= neg_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        cnt_reg    <= cnt_next;
    end

endmodule

@@ sv/pvdsw_back.sv @@
// back end: turns queued entries into serial frame words or status words
// depends on pvdsw_pkg for the entry type and frame constants
module pvdsw_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  pvdsw_pkg::entry_t  q_head,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,    // [2:0] target, [3] serial_bit, [7:4] bit_number
    output logic [1:0]         m_tuser,    // [1:0] status
    output logic               m_tlast
);

    logic               busy_reg, busy_next;
    pvdsw_pkg::entry_t  entry_reg, entry_next;
    logic [3:0]         bit_reg, bit_next;
    logic               ok;
    logic [15:0]        frame;
    logic               serial_bit;
    logic [3:0]         bit_number;
    logic               word_last;
    logic               word_done;

    // output word from the held entry
    assign ok         = (entry_reg.status == pvdsw_pkg::ST_OK);
    assign frame      = {pvdsw_pkg::CMD_BYTE, entry_reg.code};
    assign serial_bit = ok ? frame[~bit_reg] : 1'b0;
    assign bit_number = ok ? bit_reg : 4'd0;
    assign word_last  = !ok || (bit_reg == 4'(pvdsw_pkg::FRAME_BITS - 1));

    assign m_tvalid  = busy_reg;
    assign m_tdata   = {bit_number, serial_bit, entry_reg.target};
    assign m_tuser   = entry_reg.status;
    assign m_tlast   = word_last;
    assign word_done = busy_reg && m_tready;

    // load the next entry as the last word of the current one leaves
    assign q_pop = q_valid && (!busy_reg || (word_done && word_last));

    always_comb begin
        busy_next  = busy_reg;
        entry_next = entry_reg;
        bit_next   = bit_reg;
        if (q_pop) begin
            busy_next  = 1'b1;
            entry_next = q_head;
            bit_next   = 4'd0;
        end else if (word_done) begin
            if (word_last) begin
                busy_next = 1'b0;
            end else begin
                bit_next = bit_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        bit_reg   <= bit_next;
    end

endmodule

@@ sv/pulse_value_to_digipot_serial_write_top.sv @@
// Digipot serial write block.
//
// Input channel s_*: one request per word, channel (1 to 4) and control value.
// Result channel m_*: one word per frame bit, tuser carries the status and
// tlast marks bit 15 of a frame or the single word of a rejected request.
// Configuration channel cfg_*: writes one of four 64-bit registers (base,
// proportion, wiper ohms, full-scale ohms, four 16-bit lanes each); it is
// always ready, and indexes past the fourth register are dropped.
// A result passes through the front's registers, the queue and the back's entry
// register before it appears on m_*. The front takes a request in its idle state;
// a good request then makes two six-pass runs of a divider taking 4 quotient bits
// a cycle, with one check state between them, and a rejected one needs no division.
// The back sends one word a cycle while the receiver takes it, so a stream of good
// requests is paced by the frame serializer, not by the front.
// A four-entry queue parts front and back: when the receiver stalls, the
// current word holds, the queue fills, and then s_tready drops.
// Reset returns the registers to their defaults and empties the queue.
// depends on pvdsw_pkg, pvdsw_front, pvdsw_queue, pvdsw_back
module pulse_value_to_digipot_serial_write_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,      // [2:0] channel, [18:3] control_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,      // [2:0] target, [3] serial_bit, [7:4] bit_number
    output logic [1:0]  m_tuser,      // [1:0] status
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [pvdsw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0]        base_reg, prop_reg, wiper_reg, full_reg;
    logic               cfg_write;
    logic               q_push, q_full, q_pop, q_valid;
    pvdsw_pkg::entry_t  q_in, q_head;

    // configuration registers
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= pvdsw_pkg::BASE_RESET;
            prop_reg  <= pvdsw_pkg::PROP_RESET;
            wiper_reg <= pvdsw_pkg::WIPER_RESET;
            full_reg  <= pvdsw_pkg::FULL_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                pvdsw_pkg::CFG_BASE:  base_reg  <= cfg_data;
                pvdsw_pkg::CFG_PROP:  prop_reg  <= cfg_data;
                pvdsw_pkg::CFG_WIPER: wiper_reg <= cfg_data;
                pvdsw_pkg::CFG_FULL:  full_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // request checking and code calculation
    pvdsw_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .base_values     (base_reg),
        .proportions     (prop_reg),
        .wiper_ohms      (wiper_reg),
        .full_scale_ohms (full_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_entry         (q_in)
    );

    // decoupling queue
    pvdsw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

    // frame serializer
    pvdsw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ sim/pulse_value_to_digipot_serial_write_top_tb.sv @@
// self-checking testbench for the digipot serial write block: drives requests and
// register writes, predicts every frame bit or rejection word and checks the result stream
// depends on pvdsw_pkg and pulse_value_to_digipot_serial_write_top
module pulse_value_to_digipot_serial_write_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pvdsw_pkg::*;

    // fixed-point and wiper scaling, value-to-code path
    localparam longint FRAC_SCALE = 256;
    localparam longint WIPER_STEPS = 256;
    // index past the four registers, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd7;
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int IDLE_PCT = 9;

    // one request word
    typedef struct packed {
        logic [2:0]  chan;
        logic [15:0] value;
    } pot_req_t;

    // one result word
    typedef struct packed {
        status_t    status;
        logic [2:0] target;
        logic       serial_bit;
        logic [3:0] bit_number;
        logic       last;
    } pot_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;

    // register copies used for prediction
    logic [63:0] base_lanes = BASE_RESET;
    logic [63:0] prop_lanes = PROP_RESET;
    logic [63:0] wiper_lanes = WIPER_RESET;
    logic [63:0] full_lanes = FULL_RESET;
    logic [CFG_IDX_W-1:0] reg_order [4] = '{CFG_BASE, CFG_PROP, CFG_WIPER, CFG_FULL};

    pot_req_t  req_pending [$];
    pot_word_t frame_bits_due [$];
    pot_req_t  offered;
    pot_word_t seen_word;
    int        reqs_open = 0;
    int        mismatches = 0;
    bit        calm = 1'b0;
    bit        hold_wanted = 1'b0;
    bit        hold_done = 1'b0;
    int        hold_left = 0;

    pulse_value_to_digipot_serial_write_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // single rejection word
    function automatic void push_reject(input status_t why);
        pot_word_t w;
        w.status = why;
        w.target = 3'd0;
        w.serial_bit = 1'b0;
        w.bit_number = 4'd0;
        w.last = 1'b1;
        frame_bits_due.push_back(w);
    endfunction

    // expected words for one request: 16 frame bits or one rejection
    function automatic void predict_pot_write(input logic [2:0] chan, input logic [15:0] value);
        int lane;
        longint base, prop, wiper, full, ohms, steps, code_wide;
        logic [15:0] frame;
        pot_word_t w;
        if (value < VALUE_MIN || value > VALUE_MAX) begin
            push_reject(ST_RANGE);
            return;
        end
        if (chan < 1 || chan > CHANNELS) begin
            push_reject(ST_CHAN);
            return;
        end
        lane = chan - 1;
        base = longint'(base_lanes[lane*16 +: 16]);
        prop = longint'(prop_lanes[lane*16 +: 16]);
        wiper = longint'(wiper_lanes[lane*16 +: 16]);
        full = longint'(full_lanes[lane*16 +: 16]);
        if (prop == 0 || full == 0) begin
            push_reject(ST_OHMS);
            return;
        end
        // q8.8 divisor, truncation toward zero
        ohms = ((longint'(value) - base) * FRAC_SCALE) / prop;
        if (ohms < 0 || ohms > longint'(OHMS_MAX)) begin
            push_reject(ST_OHMS);
            return;
        end
        // wiper code wraps modulo 256
        steps = ((ohms - wiper) * WIPER_STEPS) / full;
        code_wide = WIPER_STEPS - steps;
        frame = {CMD_BYTE, code_wide[7:0]};
        for (int k = 0; k < FRAME_BITS; k++) begin
            w.status = ST_OK;
            w.target = chan;
            w.serial_bit = frame[FRAME_BITS-1-k];
            w.bit_number = k[3:0];
            w.last = (k == FRAME_BITS - 1);
            frame_bits_due.push_back(w);
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_pot_write(offered.chan, offered.value);
                reqs_open--;
            end
            if (!s_tvalid || s_tready) begin
                if (req_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    offered = req_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {5'd0, offered.value, offered.chan};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_wanted && !hold_done) begin
            m_tready <= 1'b0;
            hold_left <= LONG_HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_word.status = status_t'(m_tuser);
            seen_word.target = m_tdata[2:0];
            seen_word.serial_bit = m_tdata[3];
            seen_word.bit_number = m_tdata[7:4];
            seen_word.last = m_tlast;
            if (frame_bits_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word %p", seen_word));
            end else if (seen_word !== frame_bits_due[0]) begin
                report_mismatch($sformatf("got %p, want %p", seen_word, frame_bits_due.pop_front()));
            end else begin
                void'(frame_bits_due.pop_front());
            end
        end
    end

    task automatic queue_req(input logic [2:0] chan, input logic [15:0] value);
        pot_req_t r;
        r.chan = chan;
        r.value = value;
        req_pending.push_back(r);
        reqs_open++;
    endtask

    // mostly well-formed requests, the rest noise and near-miss values
    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1: queue_req(3'($urandom), 16'($urandom));
                2: queue_req(3'($urandom_range(4, 1)), $urandom_range(1) ? 16'd999 : 16'd2001);
                default: queue_req(3'($urandom_range(4, 1)), 16'($urandom_range(2000, 1000)));
            endcase
        end
    endtask

    task automatic write_cfg_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_BASE:  base_lanes = val;
            CFG_PROP:  prop_lanes = val;
            CFG_WIPER: wiper_lanes = val;
            CFG_FULL:  full_lanes = val;
            default: ;
        endcase
    endtask

    // random lanes, with extremes now and then
    function automatic logic [63:0] pick_lanes(input int lo, input int hi);
        logic [63:0] lanes;
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(7))
                0: lanes[i*16 +: 16] = 16'h0000;
                1: lanes[i*16 +: 16] = 16'hFFFF;
                default: lanes[i*16 +: 16] = 16'($urandom_range(hi, lo));
            endcase
        end
        return lanes;
    endfunction

    // every request taken and every word seen, then a short settle
    task automatic wait_drained();
        do @(posedge aclk); while (reqs_open != 0 || frame_bits_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // stimulus sequence
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // value limits, bad channels and check order at reset settings
        queue_req(3'd1, 16'd999);
        queue_req(3'd1, 16'd1000);
        queue_req(3'd1, 16'd2000);
        queue_req(3'd2, 16'd2001);
        queue_req(3'd3, 16'd0);
        queue_req(3'd4, 16'hFFFF);
        queue_req(3'd0, 16'd1500);
        queue_req(3'd5, 16'd1500);
        queue_req(3'd7, 16'd1000);
        queue_req(3'd6, 16'd2000);
        queue_req(3'd0, 16'd999);
        queue_req(3'd2, 16'd1500);
        queue_req(3'd3, 16'd1234);
        queue_req(3'd4, 16'd1999);
        wait_drained();

        // per-lane extremes: negative and wrapping codes, tiny divisor, zero full scale
        write_cfg_reg(CFG_BASE, {16'hFFFF, 16'd2000, 16'd1000, 16'd0});
        write_cfg_reg(CFG_PROP, {16'hFFFF, 16'h0001, 16'h0080, 16'h0100});
        write_cfg_reg(CFG_WIPER, {16'd100, 16'hFFFF, 16'd500, 16'd0});
        write_cfg_reg(CFG_FULL, {16'd0, 16'd10000, 16'd1, 16'hFFFF});
        write_cfg_reg(CFG_UNUSED, '1);
        for (int ch = 1; ch <= 4; ch++) begin
            queue_req(3'(ch), 16'd1000);
            queue_req(3'(ch), 16'd1500);
            queue_req(3'(ch), 16'd2000);
        end
        wait_drained();

        // all registers zero, then all ones
        foreach (reg_order[i]) write_cfg_reg(reg_order[i], 64'd0);
        queue_random(8);
        wait_drained();
        foreach (reg_order[i]) write_cfg_reg(reg_order[i], '1);
        queue_random(8);
        wait_drained();

        // random settings; long receiver stall in the first, no idling in the third
        for (int p = 0; p < 5; p++) begin
            write_cfg_reg(CFG_BASE, pick_lanes(0, 2000));
            write_cfg_reg(CFG_PROP, pick_lanes(32, 768));
            write_cfg_reg(CFG_WIPER, pick_lanes(0, 3000));
            write_cfg_reg(CFG_FULL, pick_lanes(1, 65535));
            calm = (p == 2);
            queue_random(85);
            if (p == 0) hold_wanted = 1'b1;
            wait_drained();
        end
        calm = 1'b0;

        if (mismatches == 0) begin
            $display("** pulse_value_to_digipot_serial_write_top: PASSED **");
        end else begin
            $display("** pulse_value_to_digipot_serial_write_top: FAILED **");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("** pulse_value_to_digipot_serial_write_top: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
sv/pvdsw_pkg.sv
sv/pvdsw_queue.sv
sv/pvdsw_front.sv
sv/pvdsw_back.sv
sv/pulse_value_to_digipot_serial_write_top.sv
sim/pulse_value_to_digipot_serial_write_top_tb.sv
